[hdl/mnps_pkg.sv]
`default_nettype none

package mnps_pkg;

  localparam int DEF_STACK_DEPTH = 16;

  localparam logic FUNC_NOTE_ON  = 1'b0;
  localparam logic FUNC_NOTE_OFF = 1'b1;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_SLIDE   = 2'd2;
  localparam logic [1:0] ACT_RELEASE = 2'd3;

  typedef struct packed {
    logic               func;
    logic        [15:0] note_id;
    logic signed [15:0] note_pitch;
    logic        [15:0] note_velocity;
  } evt_t;

  typedef struct packed {
    logic        [1:0]  action;
    logic        [15:0] voice_id;
    logic signed [15:0] voice_pitch;
    logic        [15:0] voice_velocity;
    logic               overflow;
    logic        [4:0]  held_count;
  } res_t;

  // one held note as stored on the stack
  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] pitch;
    logic        [15:0] velocity;
  } entry_t;

endpackage

`default_nettype wire

[hdl/mono_note_priority_stack_unit.sv]
`default_nettype none

// Channel   Dir  Handshake            Payload
// evt       in   evt_valid/evt_ready  mnps_pkg::evt_t (func, note_id, pitch, velocity)
// res       out  res_valid/res_ready  mnps_pkg::res_t (action, voice, overflow, held_count)
//
// Note on: the input transfer (stack push when not full), then the finish state.
// Note off: a search for the id (an unknown id ends there), then compaction for a release,
// a silent removal or a slide; search and compaction read one stack entry per cycle, and a
// slide takes one more read for the new top.
// Reset clears the held count and sounding voice; stack contents need none.
// evt_ready is low while an event is worked; the finish cycle stalls until the previous
// result is taken, so one result may wait while the next event is accepted.

module mono_note_priority_stack_unit #(
  parameter int STACK_DEPTH = mnps_pkg::DEF_STACK_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          evt_valid,
  output logic               evt_ready,
  input  wire mnps_pkg::evt_t evt,
  output logic               res_valid,
  input  wire logic          res_ready,
  output mnps_pkg::res_t     res
);
  import mnps_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_TOP   = 3'd3;
  localparam logic [2:0] S_TOPD  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]         state;
  logic [CW-1:0]      cnt;
  logic [15:0]        sid;
  logic               svld;
  logic [15:0]        key;
  logic [CW-1:0]      iss;
  logic               rvld;
  logic [AW-1:0]      ridx;
  logic signed [15:0] rp;
  logic [15:0]        rv;
  res_t               hold;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wentry;
  logic [AW-1:0]      raddr;
  entry_t             rentry;
  logic               rmatch;
  logic               full;
  logic               was_sounding;

  assign evt_ready    = (state == S_IDLE);
  assign full         = (cnt >= CW'(STACK_DEPTH));
  assign was_sounding = svld && (sid == key);

  mnps_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wentry (wentry),
    .raddr  (raddr),
    .key    (key),
    .rentry (rentry),
    .rmatch (rmatch)
  );

  always_comb begin
    we     = 1'b0;
    waddr  = ridx - AW'(1);
    wentry = rentry;
    raddr  = iss[AW-1:0];
    case (state)
      S_IDLE: begin
        waddr  = cnt[AW-1:0];
        wentry = '{id: evt.note_id, pitch: evt.note_pitch, velocity: evt.note_velocity};
        we     = evt_valid && (evt.func == FUNC_NOTE_ON) && !full;
      end
      S_SHIFT: begin
        we = rvld;  // entry read at ridx moves down one place
      end
      S_TOP: begin
        raddr = AW'(cnt - CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sid       <= '0;
      svld      <= 1'b0;
      rvld      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != S_FIN)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (evt_valid) begin
            key  <= evt.note_id;
            iss  <= '0;
            rvld <= 1'b0;
            if (evt.func == FUNC_NOTE_ON) begin
              sid  <= evt.note_id;
              svld <= 1'b1;
              if (!full) begin
                cnt <= cnt + CW'(1);
              end
              hold <= '{action: ACT_START, voice_id: evt.note_id,
                        voice_pitch: evt.note_pitch, voice_velocity: evt.note_velocity,
                        overflow: full,
                        held_count: full ? 5'(cnt) : 5'(cnt + CW'(1))};
              state <= S_FIN;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (rvld && rmatch) begin
            rp    <= rentry.pitch;
            rv    <= rentry.velocity;
            iss   <= CW'(ridx) + CW'(1);
            rvld  <= 1'b0;
            state <= S_SHIFT;
          end else begin
            rvld <= (iss < cnt);
            ridx <= iss[AW-1:0];
            if (iss < cnt) begin
              iss <= iss + CW'(1);
            end
            if (!rvld && (iss >= cnt)) begin
              hold  <= '{action: ACT_NONE, voice_id: '0, voice_pitch: '0,
                         voice_velocity: '0, overflow: 1'b0, held_count: 5'(cnt)};
              state <= S_FIN;
            end
          end
        end
        S_SHIFT: begin
          rvld <= (iss < cnt);
          ridx <= iss[AW-1:0];
          if (iss < cnt) begin
            iss <= iss + CW'(1);
          end
          if (!rvld && (iss >= cnt)) begin
            cnt <= cnt - CW'(1);
            if (!was_sounding) begin
              hold  <= '{action: ACT_NONE, voice_id: '0, voice_pitch: '0,
                         voice_velocity: '0, overflow: 1'b0,
                         held_count: 5'(cnt - CW'(1))};
              state <= S_FIN;
            end else if (cnt == CW'(1)) begin
              svld  <= 1'b0;
              hold  <= '{action: ACT_RELEASE, voice_id: key, voice_pitch: rp,
                         voice_velocity: rv, overflow: 1'b0, held_count: 5'd0};
              state <= S_FIN;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_TOP: begin
          state <= S_TOPD;
        end
        S_TOPD: begin
          sid   <= rentry.id;
          hold  <= '{action: ACT_SLIDE, voice_id: rentry.id, voice_pitch: rentry.pitch,
                     voice_velocity: rentry.velocity, overflow: 1'b0,
                     held_count: 5'(cnt)};
          state <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res       <= hold;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("held count above stack depth");

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_FIN)
    else $error("result loaded outside finish state");

  a_release_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(svld) |-> ($past(state) == S_SHIFT) && (cnt == '0))
    else $error("voice dropped while notes are held");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && hold.overflow |-> cnt == CW'(STACK_DEPTH))
    else $error("overflow flagged with room on the stack");

endmodule

`default_nettype wire

[hdl/mnps_stack.sv]
`default_nettype none

module mnps_stack #(
  parameter int STACK_DEPTH = mnps_pkg::DEF_STACK_DEPTH,
  parameter int AW          = $clog2(mnps_pkg::DEF_STACK_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mnps_pkg::entry_t wentry,
  input  wire logic [AW-1:0]   raddr,
  input  wire logic [15:0]     key,
  output mnps_pkg::entry_t     rentry,
  output logic                 rmatch
);
  import mnps_pkg::*;

  entry_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
  end

  // registered read port with the id compare alongside
  always_ff @(posedge clk) begin
    rentry <= mem[raddr];
    rmatch <= (mem[raddr].id == key);
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mnps_pkg::*;

  localparam int STACK_DEPTH = DEF_STACK_DEPTH;
  // a note off searches and compacts the stack; give it room
  localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_ready;
  evt_t evt = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // predictor state
  entry_t held_notes [STACK_DEPTH];
  int held_n = 0;
  logic [15:0] sound_id = '0;
  bit sound_on = 1'b0;

  res_t exp_voice_q [$];
  int err_count = 0;
  int res_seen = 0;
  bit idle_on = 1'b1;

  mono_note_priority_stack_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt(evt),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t predict_voice(evt_t e);
    res_t r;
    entry_t gone;
    int pos;
    int i;
    r = '0;
    if (e.func == FUNC_NOTE_ON) begin
      sound_id = e.note_id;
      sound_on = 1'b1;
      if (held_n < STACK_DEPTH) begin
        held_notes[held_n].id = e.note_id;
        held_notes[held_n].pitch = e.note_pitch;
        held_notes[held_n].velocity = e.note_velocity;
        held_n++;
      end else begin
        r.overflow = 1'b1;
      end
      r.action = ACT_START;
      r.voice_id = e.note_id;
      r.voice_pitch = e.note_pitch;
      r.voice_velocity = e.note_velocity;
    end else begin
      pos = -1;
      for (i = 0; i < held_n; i++)
        if (pos < 0 && held_notes[i].id == e.note_id) pos = i;
      if (pos >= 0) begin
        gone = held_notes[pos];
        for (i = pos; i < held_n - 1; i++) held_notes[i] = held_notes[i + 1];
        held_n--;
        if (sound_on && sound_id == e.note_id) begin
          if (held_n == 0) begin
            sound_on = 1'b0;
            r.action = ACT_RELEASE;
            r.voice_id = gone.id;
            r.voice_pitch = gone.pitch;
            r.voice_velocity = gone.velocity;
          end else begin
            sound_id = held_notes[held_n - 1].id;
            r.action = ACT_SLIDE;
            r.voice_id = held_notes[held_n - 1].id;
            r.voice_pitch = held_notes[held_n - 1].pitch;
            r.voice_velocity = held_notes[held_n - 1].velocity;
          end
        end
      end
    end
    r.held_count = 5'(held_n);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, res_seen, got, want);
    err_count++;
  endtask

  // one event transfer; valid stays high across back-to-back events
  task automatic send_event(evt_t e);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt <= e;
    evt_valid <= 1'b1;
    do @(posedge clk); while (!evt_ready);
    exp_voice_q = {exp_voice_q, predict_voice(e)};
  endtask

  task automatic send_note(logic func, logic [15:0] id, logic [15:0] pitch,
                           logic [15:0] vel);
    evt_t e;
    e.func = func;
    e.note_id = id;
    e.note_pitch = pitch;
    e.note_velocity = vel;
    send_event(e);
  endtask

  // sender holds off until every result is back and the block has settled
  task automatic wait_results_done();
    evt_valid <= 1'b0;
    while (exp_voice_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver side
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (exp_voice_q.size() == 0) begin
        report_mismatch("unexpected result", res.voice_id, '0);
      end else begin
        want = exp_voice_q.pop_front();
        if (res.action !== want.action)
          report_mismatch("action", 16'(res.action), 16'(want.action));
        if (res.voice_id !== want.voice_id)
          report_mismatch("voice_id", res.voice_id, want.voice_id);
        if (res.voice_pitch !== want.voice_pitch)
          report_mismatch("voice_pitch", res.voice_pitch, want.voice_pitch);
        if (res.voice_velocity !== want.voice_velocity)
          report_mismatch("voice_velocity", res.voice_velocity, want.voice_velocity);
        if (res.overflow !== want.overflow)
          report_mismatch("overflow", 16'(res.overflow), 16'(want.overflow));
        if (res.held_count !== want.held_count)
          report_mismatch("held_count", 16'(res.held_count), 16'(want.held_count));
      end
      res_seen++;
    end
  end

  // extremes, duplicates, unknown and non-sounding note offs, slide and release
  task automatic test_basic_events();
    send_note(FUNC_NOTE_OFF, 16'h0005, 16'h0000, 16'h0000);  // empty stack
    send_note(FUNC_NOTE_ON, 16'h0000, 16'h8000, 16'h0000);
    send_note(FUNC_NOTE_ON, 16'hFFFF, 16'h7FFF, 16'hFFFF);
    send_note(FUNC_NOTE_ON, 16'h0000, 16'h0100, 16'h8000);  // duplicate id
    send_note(FUNC_NOTE_OFF, 16'h0000, 16'hFFFF, 16'hFFFF);  // oldest copy goes, slide
    send_note(FUNC_NOTE_OFF, 16'hFFFF, 16'h1234, 16'h5678);  // not sounding
    send_note(FUNC_NOTE_OFF, 16'h1234, 16'h0000, 16'h0000);  // unknown id
    send_note(FUNC_NOTE_OFF, 16'h0000, 16'h0000, 16'h0000);  // release
    wait_results_done();
  endtask

  task automatic test_overflow();
    int i;
    for (i = 0; i < STACK_DEPTH; i++)
      send_note(FUNC_NOTE_ON, 16'(16'h0100 + i), 16'(i * 16'h0101), 16'(16'hF000 - i));
    send_note(FUNC_NOTE_ON, 16'hABCD, 16'hC000, 16'h4000);
    wait_results_done();
  endtask

  // note offs mostly of held ids, a few stray ids; half the note ons reuse a small id pool
  task automatic run_random(int count, int on_pct);
    evt_t e;
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      e.note_pitch = 16'($urandom);
      e.note_velocity = 16'($urandom);
      if ($urandom_range(0, 99) < on_pct) begin
        e.func = FUNC_NOTE_ON;
        e.note_id = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      end else begin
        e.func = FUNC_NOTE_OFF;
        pick = $urandom_range(0, 9);
        if (pick < 7 && held_n > 0)
          e.note_id = held_notes[$urandom_range(0, held_n - 1)].id;
        else if (pick < 8)
          e.note_id = sound_id;
        else
          e.note_id = 16'($urandom);
      end
      send_event(e);
    end
  endtask

  task automatic test_random_mixed();
    run_random(140, 50);
    wait_results_done();
  endtask

  task automatic test_random_fill();
    run_random(100, 75);
    wait_results_done();
  endtask

  task automatic test_random_drain();
    run_random(100, 30);
    wait_results_done();
  endtask

  task automatic test_random_no_idle();
    idle_on = 1'b0;
    run_random(110, 50);
    idle_on = 1'b1;
    run_random(10, 20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_events();
    test_overflow();
    test_random_drain();
    test_random_fill();
    test_random_mixed();
    test_random_no_idle();
    wait_results_done();
    if (exp_voice_q.size() != 0)
      report_mismatch("missing results", 16'(exp_voice_q.size()), '0);
    if (err_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
